[rtl/core/chained_hash_table_core_assert.svh]
// Assertion helpers for the hash table core.
// Each helper expects clk and rst_n to be visible where it is used.
`ifndef CHAINED_HASH_TABLE_CORE_ASSERT_SVH
`define CHAINED_HASH_TABLE_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CHT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cht_pkg.sv]
`timescale 1ns / 1ps

package cht_pkg;

    // Default sizing of the core
    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int POOL_DEPTH_DEF  = 16384;
    localparam int KEY_WIDTH_DEF   = 16;

    // Bucket count register
    localparam int          BC_W               = 11;
    localparam logic [10:0] BUCKET_COUNT_RESET = 11'd1009;
    localparam int          BC_LIMIT           = (1 << BC_W) - 1;

    // Result fields
    localparam int PROBES_W = 15;
    localparam logic [PROBES_W-1:0] PROBES_MAX = {PROBES_W{1'b1}};

    // Operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_BKT   = 6'b001000,
        S_LINK  = 6'b010000,
        S_WALK  = 6'b100000
    } state_t;

endpackage

[rtl/core/cht_ram.sv]
`timescale 1ns / 1ps

module cht_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/cht_mod.sv]
`timescale 1ns / 1ps

module cht_mod
    import cht_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] dividend,
    input  logic [BC_W-1:0]      divisor,
    output logic                 done,
    output logic [BC_W-1:0]      rem
);

    localparam int CNT_W = $clog2(KEY_WIDTH + 1);

    logic                 active_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [KEY_WIDTH-1:0] shift_reg;
    logic [BC_W-1:0]      rem_reg;
    logic [BC_W:0]        trial;
    logic [BC_W-1:0]      rem_next;

    // Shift in one dividend bit and subtract the divisor when it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[KEY_WIDTH-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = BC_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[BC_W-1:0];
        end
    end

    // Sequence one remainder step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(KEY_WIDTH);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Hold the dividend and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (active_reg)
        begin
            shift_reg <= {shift_reg[KEY_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/chained_hash_table_core.sv]
`timescale 1ns / 1ps
// Channel   Handshake         Payload
// command   start / busy      cmd, key
// result    done (one cycle)  found, probes, status
// config    cfg_we            cfg_wdata (bucket count)
//
// After a beat is accepted, busy stays high through the KEY_WIDTH remainder
// steps, the read of the bucket entry and the step that acts on it. An insert
// into a non-empty chain adds a link state; a search walks the chain node by
// node, comparing each key. The result strobe comes in the first idle cycle,
// which can also accept the next beat. After reset a clearing pass empties the
// bucket memory with busy high. The receiver cannot stall results.

`include "chained_hash_table_core_assert.svh"

module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic                 cfg_we,
    input  logic [BC_W-1:0]      cfg_wdata,
    output logic                 done,
    output logic                 found,
    output logic [PROBES_W-1:0]  probes,
    output logic                 status
);

    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int PW     = $clog2(POOL_DEPTH);
    localparam int NUW    = $clog2(POOL_DEPTH + 1);
    localparam int BKT_W  = 1 + 2 * PW;
    localparam int NXT_W  = 1 + PW;
    localparam int BC_MAX = (NUM_BUCKETS < BC_LIMIT) ? NUM_BUCKETS : BC_LIMIT;

    state_t               state_reg, state_next;
    logic [BC_W-1:0]      bucket_count_reg;
    logic [BW-1:0]        clr_cnt_reg;
    logic [NUW-1:0]       nodes_used_reg;
    logic                 cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [PROBES_W-1:0]  probes_reg, probes_next;
    logic [PW-1:0]        link_tail_reg;
    logic [PW-1:0]        link_node_reg;
    logic                 done_reg, found_reg, status_reg;
    logic [PROBES_W-1:0]  probes_out_reg;

    logic                 accept;
    logic [BC_W-1:0]      divisor;
    logic                 mod_done;
    logic [BC_W-1:0]      mod_rem;

    logic                 emit, res_found, res_status;
    logic [PROBES_W-1:0]  res_probes;
    logic                 do_alloc;

    logic                 bkt_we, bkt_re;
    logic [BW-1:0]        bkt_waddr, bkt_raddr;
    logic [BKT_W-1:0]     bkt_wdata, bkt_rdata;
    logic                 bkt_valid;
    logic [PW-1:0]        bkt_head, bkt_tail;

    logic                 nkey_we, node_re;
    logic [PW-1:0]        node_raddr, new_node;
    logic [KEY_WIDTH-1:0] nkey_rdata;
    logic                 nnxt_we;
    logic [PW-1:0]        nnxt_waddr;
    logic [NXT_W-1:0]     nnxt_wdata, nnxt_rdata;
    logic                 pool_full;
    logic [PROBES_W-1:0]  probes_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign new_node  = nodes_used_reg[PW-1:0];
    assign pool_full = (nodes_used_reg == NUW'(POOL_DEPTH));
    assign bkt_valid = bkt_rdata[BKT_W-1];
    assign bkt_head  = bkt_rdata[2*PW-1:PW];
    assign bkt_tail  = bkt_rdata[PW-1:0];
    assign probes_inc = (probes_reg == PROBES_MAX) ? probes_reg : probes_reg + PROBES_W'(1);

    // Clamp the bucket count into its usable range
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            divisor = BC_W'(1);
        end
        else if (32'(bucket_count_reg) > BC_MAX)
        begin
            divisor = BC_W'(BC_MAX);
        end
        else
        begin
            divisor = bucket_count_reg;
        end
    end

    cht_mod #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (key),
        .divisor  (divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Bucket memory: valid, head, tail
    cht_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (BKT_W)
    ) u_bkt_ram (
        .clk     (clk),
        .wr_en   (bkt_we),
        .wr_addr (bkt_waddr),
        .wr_data (bkt_wdata),
        .rd_en   (bkt_re),
        .rd_addr (bkt_raddr),
        .rd_data (bkt_rdata)
    );

    // Node key memory
    cht_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (nkey_we),
        .wr_addr (new_node),
        .wr_data (key_reg),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (nkey_rdata)
    );

    // Node successor memory: valid, index
    cht_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (NXT_W)
    ) u_nxt_ram (
        .clk     (clk),
        .wr_en   (nnxt_we),
        .wr_addr (nnxt_waddr),
        .wr_data (nnxt_wdata),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (nnxt_rdata)
    );

    // Sequence the clear pass, hashing, bucket update, chain link and chain walk
    always_comb
    begin
        state_next  = state_reg;
        probes_next = probes_reg;
        emit        = 1'b0;
        res_found   = 1'b0;
        res_status  = STATUS_DONE;
        res_probes  = '0;
        do_alloc    = 1'b0;
        bkt_we      = 1'b0;
        bkt_waddr   = clr_cnt_reg;
        bkt_wdata   = '0;
        bkt_re      = 1'b0;
        bkt_raddr   = BW'(mod_rem);
        nkey_we     = 1'b0;
        nnxt_we     = 1'b0;
        nnxt_waddr  = new_node;
        nnxt_wdata  = '0;
        node_re     = 1'b0;
        node_raddr  = bkt_head;
        unique case (state_reg)
            S_CLEAR:
            begin
                bkt_we = 1'b1;
                if (clr_cnt_reg == BW'(NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    bkt_re     = 1'b1;
                    state_next = S_BKT;
                end
            end
            S_BKT:
            begin
                probes_next = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (pool_full)
                    begin
                        emit       = 1'b1;
                        res_status = STATUS_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        do_alloc  = 1'b1;
                        nkey_we   = 1'b1;
                        nnxt_we   = 1'b1;
                        bkt_we    = 1'b1;
                        bkt_waddr = BW'(mod_rem);
                        if (bkt_valid)
                        begin
                            bkt_wdata  = {1'b1, bkt_head, new_node};
                            state_next = S_LINK;
                        end
                        else
                        begin
                            bkt_wdata  = {1'b1, new_node, new_node};
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    if (bkt_valid)
                    begin
                        node_re    = 1'b1;
                        node_raddr = bkt_head;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_LINK:
            begin
                nnxt_we    = 1'b1;
                nnxt_waddr = link_tail_reg;
                nnxt_wdata = {1'b1, link_node_reg};
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                probes_next = probes_inc;
                res_probes  = probes_inc;
                if (nkey_rdata == key_reg)
                begin
                    emit       = 1'b1;
                    res_found  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (nnxt_rdata[PW])
                begin
                    node_re    = 1'b1;
                    node_raddr = nnxt_rdata[PW-1:0];
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            bucket_count_reg <= BUCKET_COUNT_RESET;
            clr_cnt_reg      <= '0;
            nodes_used_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (cfg_we)
            begin
                bucket_count_reg <= cfg_wdata;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
            if (do_alloc)
            begin
                nodes_used_reg <= nodes_used_reg + NUW'(1);
            end
        end
    end

    // Hold the command beat, walk count, link target and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
        end
        probes_reg <= probes_next;
        if (do_alloc)
        begin
            link_tail_reg <= bkt_tail;
            link_node_reg <= new_node;
        end
        if (emit)
        begin
            found_reg      <= res_found;
            probes_out_reg <= res_probes;
            status_reg     <= res_status;
        end
    end

    assign done   = done_reg;
    assign found  = found_reg;
    assign probes = probes_out_reg;
    assign status = status_reg;

    `CHT_ASSERT_NEXT(a_accept_hash, accept, state_reg == S_HASH, "accepted beat did not start hashing")
    `CHT_ASSERT_SAME(a_done_busy, done, $past(busy), "result beat without a busy cycle before it")
    `CHT_ASSERT_SAME(a_full_clean, done && status == STATUS_FULL, !found && probes == '0, "refused insert reports search fields")
    `CHT_ASSERT_SAME(a_alloc_insert, !$stable(nodes_used_reg), $past(state_reg == S_BKT && cmd_reg == CMD_INSERT), "pool count moved outside an insert")

endmodule
